// ===== rtl/trlm_pkg.sv =====
package trlm_pkg;

    // Default sizes handed to the top level
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS_DEF = 24;

    // Fixed-point formats
    localparam int GUARD_BITS   = 8;
    localparam int ANGLE_FRAC   = 20;
    localparam int ANG_W        = 28;
    localparam int ATAN_W       = 26;
    localparam int SHIFT_W      = 5;
    localparam int INV_GAIN_W   = 20;
    localparam logic [INV_GAIN_W-1:0] INV_GAIN_Q20 = 20'd636751;

    // Result and register widths
    localparam int ROLL_W     = 10;
    localparam int LIMIT_W    = 10;
    localparam int OFFSET_W   = 9;
    localparam int DEG_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic signed [LIMIT_W-1:0]  LIMIT_RESET  = 10'sd30;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 9'sd0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;

    // Whole-degree angles
    localparam logic [DEG_W-1:0] DEG_ZERO  = 7'd0;
    localparam logic [DEG_W-1:0] DEG_30    = 7'd30;
    localparam logic [DEG_W-1:0] DEG_45    = 7'd45;
    localparam logic [DEG_W-1:0] DEG_60    = 7'd60;
    localparam logic [DEG_W-1:0] DEG_MAX   = 7'd89;
    localparam logic [DEG_W-1:0] DEG_RIGHT = 7'd90;

    // atan(2^-k) in degrees, Q20
    localparam logic [ATAN_W-1:0] ATAN_DEG_Q20 [32] = '{
        26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121,
        26'd3750058,  26'd1876857,  26'd938658,   26'd469357,
        26'd234682,   26'd117342,   26'd58671,    26'd29335,
        26'd14668,    26'd7334,     26'd3667,     26'd1833,
        26'd917,      26'd458,      26'd229,      26'd115,
        26'd57,       26'd29,       26'd14,       26'd7,
        26'd4,        26'd2,        26'd1,        26'd0,
        26'd0,        26'd0,        26'd0,        26'd0
    };

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_TRIPLE,
        ST_CHECK,
        ST_VEC1,
        ST_GAIN,
        ST_VEC2,
        ST_ANGLE,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/trlm_cordic_step.sv =====
module trlm_cordic_step #(
    parameter int W = 27
) (
    input  logic signed [W-1:0]                i_x,
    input  logic signed [W-1:0]                i_y,
    input  logic signed [trlm_pkg::ANG_W-1:0]  i_z,
    input  logic [trlm_pkg::SHIFT_W-1:0]       i_k,
    output logic signed [W-1:0]                o_x,
    output logic signed [W-1:0]                o_y,
    output logic signed [trlm_pkg::ANG_W-1:0]  o_z
);
    import trlm_pkg::*;

    logic signed [W-1:0]     dx;
    logic signed [W-1:0]     dy;
    logic signed [ANG_W-1:0] step_ang;

    // shifts round toward minus infinity
    assign dx       = i_y >>> i_k;
    assign dy       = i_x >>> i_k;
    assign step_ang = ANG_W'(ATAN_DEG_Q20[i_k]);

    // vectoring: rotate down while y is not negative
    always_comb begin
        if (!i_y[W-1]) begin
            o_x = i_x + dx;
            o_y = i_y - dy;
            o_z = i_z + step_ang;
        end else begin
            o_x = i_x - dx;
            o_y = i_y + dy;
            o_z = i_z - step_ang;
        end
    end

endmodule

// ===== rtl/tilt_roll_limit_monitor.sv =====
// Roll angle monitor. Each accepted beat (accel_x, accel_y, accel_z) yields one result
// beat: roll_deg = sign(y) * trunc(atan2(|y|, sqrt(x^2 + z^2))) in whole degrees plus
// angle_offset, with a change flag, an over-limit flag (roll_deg > angle_limit) and one-shot
// raise/clear events. Exact angles (0, 30, 45, 60, 90) are found by integer tests on the
// squares; the rest run two CORDIC vectoring passes, magnitude then angle, through one
// shared shift-add stage at one iteration per cycle; an exact angle skips both passes.
// The input stalls for the whole computation; a finished result waits in the output
// register while the next sample is taken.
// Write the configuration only while no sample is in flight; a write takes effect at once.
module tilt_roll_limit_monitor #(
    parameter int SAMPLE_WIDTH = trlm_pkg::SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = trlm_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sample channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_accel_z,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [trlm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [trlm_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [trlm_pkg::ROLL_W-1:0]    o_roll_deg,
    output logic                                  o_roll_changed,
    output logic                                  o_above_limit,
    output logic                                  o_warn_raise,
    output logic                                  o_warn_clear
);
    import trlm_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int W     = SW + GUARD_BITS + 3;
    localparam int SQ_W  = 2 * SW;
    localparam int TRI_W = SQ_W + 2;
    localparam int MB_W  = (SW > INV_GAIN_W) ? SW : INV_GAIN_W;
    localparam int P_W   = W + MB_W;
    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam int WHL_W = ANG_W - ANGLE_FRAC;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] SQ_X      = CNT_W'(0);
    localparam logic [CNT_W-1:0] SQ_Y      = CNT_W'(1);
    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(2);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;

    // sample magnitudes and squares
    logic [SW-1:0]    r_xa, r_ya, r_za;
    logic             r_yneg;
    logic [SQ_W-1:0]  r_x2, r_y2, r_z2;
    logic [SQ_W:0]    r_s;
    logic [TRI_W-1:0] r_y3, r_s3;

    // CORDIC registers
    logic signed [W-1:0]     r_cx, r_cy;
    logic signed [ANG_W-1:0] r_cz;
    logic [DEG_W-1:0]        r_deg;

    // configuration and history
    logic signed [LIMIT_W-1:0]  r_limit;
    logic signed [OFFSET_W-1:0] r_offset;
    logic signed [ROLL_W-1:0]   r_prev_roll;
    logic                       r_prev_valid;
    logic                       r_warn;

    // result register
    logic                       r_out_valid;
    logic signed [ROLL_W-1:0]   r_roll;
    logic                       r_changed, r_over, r_raise, r_clear;

    // combinational helpers
    logic                       step_last;
    logic                       out_free;
    logic                       out_load;
    logic                       is_exact;
    logic [DEG_W-1:0]           exact_deg;
    logic [DEG_W-1:0]           angle_deg;
    logic [WHL_W-1:0]           whole;
    logic [SW-1:0]              mag_x, mag_y, mag_z;
    logic [W-1:0]               mul_a;
    logic [MB_W-1:0]            mul_b;
    logic [P_W-1:0]             mul_p;
    logic signed [W-1:0]        st_x, st_y;
    logic signed [ANG_W-1:0]    st_z;
    logic signed [ROLL_W-1:0]   deg_s, roll, signed_deg;
    logic                       over;

    // sample magnitudes; the most negative value maps to its unsigned magnitude
    assign mag_x = i_accel_x[SW-1] ? SW'(-i_accel_x) : i_accel_x;
    assign mag_y = i_accel_y[SW-1] ? SW'(-i_accel_y) : i_accel_y;
    assign mag_z = i_accel_z[SW-1] ? SW'(-i_accel_z) : i_accel_z;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_SQUARE;
            ST_SQUARE: if (r_cnt == SQ_LAST) n_state = ST_SUM;
            ST_SUM:    n_state = ST_TRIPLE;
            ST_TRIPLE: n_state = ST_CHECK;
            ST_CHECK:  n_state = is_exact ? ST_DONE : ST_VEC1;
            ST_VEC1:   if (step_last) n_state = ST_GAIN;
            ST_GAIN:   n_state = ST_VEC2;
            ST_VEC2:   if (step_last) n_state = ST_ANGLE;
            ST_ANGLE:  n_state = ST_DONE;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        step_last  = (r_cnt == LAST_STEP);
        out_free   = !r_out_valid || !i_out_stall;
        out_load   = (r_state == ST_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state != n_state) ? '0 : r_cnt + CNT_W'(1);
        end
    end

    // shared multiplier: squares, then the inverse-gain correction
    always_comb begin
        if (r_state == ST_GAIN) begin
            mul_a = r_cx[W-1] ? '0 : W'(unsigned'(r_cx));
            mul_b = MB_W'(INV_GAIN_Q20);
        end else begin
            case (r_cnt)
                SQ_X: begin
                    mul_a = W'(r_xa);
                    mul_b = MB_W'(r_xa);
                end
                SQ_Y: begin
                    mul_a = W'(r_ya);
                    mul_b = MB_W'(r_ya);
                end
                default: begin
                    mul_a = W'(r_za);
                    mul_b = MB_W'(r_za);
                end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    // shared CORDIC iteration
    trlm_cordic_step #(
        .W (W)
    ) u_step (
        .i_x (r_cx),
        .i_y (r_cy),
        .i_z (r_cz),
        .i_k (SHIFT_W'(r_cnt)),
        .o_x (st_x),
        .o_y (st_y),
        .o_z (st_z)
    );

    // exact-angle tests on the squares
    always_comb begin
        is_exact  = 1'b1;
        exact_deg = DEG_60;
        if (r_ya == '0) begin
            exact_deg = DEG_ZERO;
        end else if (r_s == '0) begin
            exact_deg = DEG_RIGHT;
        end else if ((SQ_W + 1)'(r_y2) == r_s) begin
            exact_deg = DEG_45;
        end else if (r_y3 == TRI_W'(r_s)) begin
            exact_deg = DEG_30;
        end else if (TRI_W'(r_y2) == r_s3) begin
            exact_deg = DEG_60;
        end else begin
            is_exact = 1'b0;
        end
    end

    // whole degrees from the angle accumulator, held within 0..89
    always_comb begin
        whole = r_cz[ANG_W-1:ANGLE_FRAC];
        if (r_cz[ANG_W-1]) begin
            angle_deg = DEG_ZERO;
        end else if (whole > WHL_W'(DEG_MAX)) begin
            angle_deg = DEG_MAX;
        end else begin
            angle_deg = DEG_W'(whole);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_xa   <= mag_x;
                    r_ya   <= mag_y;
                    r_za   <= mag_z;
                    r_yneg <= i_accel_y[SW-1];
                end
            end
            ST_SQUARE: begin
                case (r_cnt)
                    SQ_X:    r_x2 <= mul_p[SQ_W-1:0];
                    SQ_Y:    r_y2 <= mul_p[SQ_W-1:0];
                    default: r_z2 <= mul_p[SQ_W-1:0];
                endcase
            end
            ST_SUM: begin
                r_s  <= (SQ_W + 1)'(r_x2) + (SQ_W + 1)'(r_z2);
                r_y3 <= TRI_W'(r_y2) + (TRI_W'(r_y2) << 1);
            end
            ST_TRIPLE: begin
                r_s3 <= TRI_W'(r_s) + (TRI_W'(r_s) << 1);
            end
            ST_CHECK: begin
                r_deg <= exact_deg;
                r_cx  <= signed'(W'(r_xa) << GUARD_BITS);
                r_cy  <= signed'(W'(r_za) << GUARD_BITS);
            end
            ST_VEC1: begin
                r_cx <= st_x;
                r_cy <= st_y;
            end
            ST_GAIN: begin
                r_cx <= signed'(W'(mul_p >> ANGLE_FRAC));
                r_cy <= signed'(W'(r_ya) << GUARD_BITS);
                r_cz <= '0;
            end
            ST_VEC2: begin
                r_cx <= st_x;
                r_cy <= st_y;
                r_cz <= st_z;
            end
            ST_ANGLE: begin
                r_deg <= angle_deg;
            end
            default: begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RESET;
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIMIT:  r_limit  <= signed'(i_cfg_data[LIMIT_W-1:0]);
                CFG_OFFSET: r_offset <= signed'(i_cfg_data[OFFSET_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // signed roll and limit compare
    always_comb begin
        deg_s      = signed'(ROLL_W'(r_deg));
        signed_deg = r_yneg ? -deg_s : deg_s;
        roll       = signed_deg + ROLL_W'(r_offset);
        over       = roll > r_limit;
    end

    // history and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_prev_roll  <= '0;
            r_prev_valid <= 1'b0;
            r_warn       <= 1'b0;
        end else if (out_load) begin
            r_out_valid  <= 1'b1;
            r_prev_roll  <= roll;
            r_prev_valid <= 1'b1;
            r_warn       <= over;
        end else if (!i_out_stall) begin
            r_out_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_roll    <= roll;
            r_changed <= !r_prev_valid || (roll != r_prev_roll);
            r_over    <= over;
            r_raise   <= over && !r_warn;
            r_clear   <= !over && r_warn;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_roll_deg     = r_roll;
    assign o_roll_changed = r_changed;
    assign o_above_limit  = r_over;
    assign o_warn_raise   = r_raise;
    assign o_warn_clear   = r_clear;

endmodule

// ===== rtl/trlm_checker.sv =====
module trlm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_above_limit,
    input logic o_warn_raise,
    input logic o_warn_clear
);

    // a stalled result beat is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // one sample at a time: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sample taken while busy");

    // raise and clear never together
    a_events_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_warn_raise && o_warn_clear))
        else $error("raise and clear in the same beat");

    // a raise always comes with the flag set
    a_raise_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_warn_raise) |-> o_above_limit)
        else $error("raise without over limit");

    // a clear always comes with the flag low
    a_clear_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_warn_clear) |-> !o_above_limit)
        else $error("clear while over limit");

endmodule

bind tilt_roll_limit_monitor trlm_checker u_trlm_checker (.*);
